FILE: rtl/lwc_pkg.sv
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared codes and types for the lock wait chain deadlock checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwc_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned LockIdW = 6;
  localparam int unsigned ThreadIdW = 4;

  // Operation codes carried in the func field of an input item.
  localparam logic [FuncW-1:0] FUNC_SET_OWNER = 3'd0;
  localparam logic [FuncW-1:0] FUNC_CLR_OWNER = 3'd1;
  localparam logic [FuncW-1:0] FUNC_SET_WAIT  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_CLR_WAIT  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DL_QUERY  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_TAIL_QRY  = 3'd5;

  // Update command for the wait table.
  typedef struct packed {
    logic set;
    logic clr;
  } wt_upd_t;

endpackage

FILE: rtl/lock_wait_chain_deadlock_checker_core.sv
// ----------------------------------------------------------------------------
// lock_wait_chain_deadlock_checker_core
// Wait-for table of lock owners and waited locks with deadlock and
// wait-chain tail queries.
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+----------------------------------------
//   in      | in_valid_i/in_ready_o   | func_i, lock_id_i, thread_id_i
//   out     | out_valid_o/out_ready_i | deadlock_found_o, tail_thread_o,
//           |                         | chain_cycled_o
//
// An update holds the block from its accept through the finish state, and its
// result is loaded into the output register from that state. A deadlock query
// or a tail query holds it while it walks the wait chain, one chain link per
// cycle, set by the single read port of the owner table. After reset the owner
// table is cleared before the first item is accepted. A stalled result is held
// in the output register while the next item is taken; that item then waits
// until the result goes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lock_wait_chain_deadlock_checker_core #(
  parameter int unsigned NUM_LOCKS   = 64,
  parameter int unsigned NUM_THREADS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [5:0] lock_id_i,
  input  logic [3:0] thread_id_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       deadlock_found_o,
  output logic [3:0] tail_thread_o,
  output logic       chain_cycled_o
);

  import lwc_pkg::*;

  localparam int unsigned LW = $clog2(NUM_LOCKS);
  localparam int unsigned TW = $clog2(NUM_THREADS);

  logic          ram_we;
  logic [LW-1:0] ram_waddr;
  logic [TW:0]   ram_wdata;
  logic [LW-1:0] ram_raddr;
  logic [TW:0]   ram_rdata;
  wt_upd_t       wt_upd;
  logic [TW-1:0] wt_thread;
  logic [LW-1:0] wt_lock;
  logic [TW-1:0] wt_rd_thread;
  logic          wt_rd_vld;
  logic [LW-1:0] wt_rd_lock;

  lwc_owner_ram #(
    .DEPTH (NUM_LOCKS),
    .WIDTH (TW + 1)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lwc_wait_tbl #(
    .NUM_LOCKS   (NUM_LOCKS),
    .NUM_THREADS (NUM_THREADS)
  ) u_wait_tbl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (wt_upd),
    .upd_thread_i (wt_thread),
    .upd_lock_i   (wt_lock),
    .rd_thread_i  (wt_rd_thread),
    .rd_vld_o     (wt_rd_vld),
    .rd_lock_o    (wt_rd_lock)
  );

  lwc_walk_ctrl #(
    .NUM_LOCKS   (NUM_LOCKS),
    .NUM_THREADS (NUM_THREADS)
  ) u_walk_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .lock_id_i        (lock_id_i),
    .thread_id_i      (thread_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .deadlock_found_o (deadlock_found_o),
    .tail_thread_o    (tail_thread_o),
    .chain_cycled_o   (chain_cycled_o),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .wt_upd_o         (wt_upd),
    .wt_thread_o      (wt_thread),
    .wt_lock_o        (wt_lock),
    .wt_rd_thread_o   (wt_rd_thread),
    .wt_rd_vld_i      (wt_rd_vld),
    .wt_rd_lock_i     (wt_rd_lock)
  );

endmodule

FILE: rtl/lwc_owner_ram.sv
// ----------------------------------------------------------------------------
// lwc_owner_ram
// Owner table: one valid bit and one owner thread per lock, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwc_owner_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lwc_wait_tbl.sv
// ----------------------------------------------------------------------------
// lwc_wait_tbl
// Wait table: for each thread a valid bit and the lock it waits for, with
// one update port and one lookup port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwc_wait_tbl #(
  parameter int unsigned NUM_LOCKS   = 64,
  parameter int unsigned NUM_THREADS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lwc_pkg::wt_upd_t               upd_i,
  input  logic [$clog2(NUM_THREADS)-1:0] upd_thread_i,
  input  logic [$clog2(NUM_LOCKS)-1:0]   upd_lock_i,
  input  logic [$clog2(NUM_THREADS)-1:0] rd_thread_i,
  output logic                           rd_vld_o,
  output logic [$clog2(NUM_LOCKS)-1:0]   rd_lock_o
);

  import lwc_pkg::*;

  localparam int unsigned LW = $clog2(NUM_LOCKS);

  logic [NUM_THREADS-1:0] vld_q;
  logic [LW-1:0]          lock_q [NUM_THREADS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (upd_i.set) begin
      vld_q[upd_thread_i] <= 1'b1;
    end else if (upd_i.clr) begin
      vld_q[upd_thread_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.set) begin
      lock_q[upd_thread_i] <= upd_lock_i;
    end
  end

  assign rd_vld_o  = vld_q[rd_thread_i];
  assign rd_lock_o = lock_q[rd_thread_i];

endmodule

FILE: rtl/lwc_walk_ctrl.sv
// ----------------------------------------------------------------------------
// lwc_walk_ctrl
// Sequencer: applies updates, clears the owner table after reset, walks
// wait chains one link per cycle and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwc_walk_ctrl #(
  parameter int unsigned NUM_LOCKS   = 64,
  parameter int unsigned NUM_THREADS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     func_i,
  input  logic [5:0]                     lock_id_i,
  input  logic [3:0]                     thread_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           deadlock_found_o,
  output logic [3:0]                     tail_thread_o,
  output logic                           chain_cycled_o,
  output logic                           ram_we_o,
  output logic [$clog2(NUM_LOCKS)-1:0]   ram_waddr_o,
  output logic [$clog2(NUM_THREADS):0]   ram_wdata_o,
  output logic [$clog2(NUM_LOCKS)-1:0]   ram_raddr_o,
  input  logic [$clog2(NUM_THREADS):0]   ram_rdata_i,
  output lwc_pkg::wt_upd_t               wt_upd_o,
  output logic [$clog2(NUM_THREADS)-1:0] wt_thread_o,
  output logic [$clog2(NUM_LOCKS)-1:0]   wt_lock_o,
  output logic [$clog2(NUM_THREADS)-1:0] wt_rd_thread_o,
  input  logic                           wt_rd_vld_i,
  input  logic [$clog2(NUM_LOCKS)-1:0]   wt_rd_lock_i
);

  import lwc_pkg::*;

  localparam int unsigned LW = $clog2(NUM_LOCKS);
  localparam int unsigned TW = $clog2(NUM_THREADS);
  localparam int unsigned CW = $clog2(NUM_LOCKS + 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          tail_mode_q, tail_mode_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] cur_q, cur_d;
  logic [LW-1:0] clr_q, clr_d;
  logic          res_found_q, res_found_d;
  logic [3:0]    res_tail_q, res_tail_d;
  logic          res_cyc_q, res_cyc_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;

  logic              accept;
  logic              lock_ok;
  logic              thr_ok;
  logic [LW+5:0]     lock_wide;
  logic [TW+3:0]     thr_wide;
  logic [LW-1:0]     lock_idx;
  logic [TW-1:0]     thr_idx;
  logic              ram_vld;
  logic [TW-1:0]     ram_thread;
  logic [TW+3:0]     cur_wide;
  logic [TW+3:0]     nxt_wide;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  assign lock_ok   = ({26'd0, lock_id_i} < 32'(NUM_LOCKS));
  assign thr_ok    = ({28'd0, thread_id_i} < 32'(NUM_THREADS));
  assign lock_wide = {{LW{1'b0}}, lock_id_i};
  assign thr_wide  = {{TW{1'b0}}, thread_id_i};
  assign lock_idx  = lock_wide[LW-1:0];
  assign thr_idx   = thr_wide[TW-1:0];

  assign ram_vld    = ram_rdata_i[TW];
  assign ram_thread = ram_rdata_i[TW-1:0];
  assign cur_wide   = {4'd0, cur_q};
  assign nxt_wide   = {4'd0, ram_thread};

  assign wt_thread_o = thr_idx;
  assign wt_lock_o   = lock_idx;

  always_comb begin
    state_d        = state_q;
    tail_mode_d    = tail_mode_q;
    cnt_d          = cnt_q;
    cur_d          = cur_q;
    clr_d          = clr_q;
    res_found_d    = res_found_q;
    res_tail_d     = res_tail_q;
    res_cyc_d      = res_cyc_q;
    out_load       = 1'b0;
    ram_we_o       = 1'b0;
    ram_waddr_o    = lock_idx;
    ram_wdata_o    = '0;
    ram_raddr_o    = lock_idx;
    wt_upd_o       = '0;
    wt_rd_thread_o = thr_idx;

    unique case (state_q)
      ST_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        if (clr_q == LW'(NUM_LOCKS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_found_d = 1'b0;
          res_tail_d  = '0;
          res_cyc_d   = 1'b0;
          cnt_d       = '0;
          cur_d       = thr_idx;
          state_d     = ST_FIN;
          unique case (func_i)
            FUNC_SET_OWNER: begin
              if (lock_ok && thr_ok) begin
                ram_we_o    = 1'b1;
                ram_wdata_o = {1'b1, thr_idx};
              end
            end
            FUNC_CLR_OWNER: begin
              ram_we_o = lock_ok;
            end
            FUNC_SET_WAIT: begin
              wt_upd_o.set = lock_ok && thr_ok;
            end
            FUNC_CLR_WAIT: begin
              wt_upd_o.clr = thr_ok;
            end
            FUNC_DL_QUERY: begin
              if (lock_ok) begin
                tail_mode_d = 1'b0;
                state_d     = ST_RUN;
              end
            end
            FUNC_TAIL_QRY: begin
              // A thread outside the table, or one that waits for nothing,
              // is its own tail.
              res_tail_d = thread_id_i;
              if (thr_ok && wt_rd_vld_i) begin
                ram_raddr_o = wt_rd_lock_i;
                tail_mode_d = 1'b1;
                state_d     = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        wt_rd_thread_o = ram_thread;
        if (!tail_mode_q) begin
          // A chain that survives as many links as there are locks must
          // have come back to a lock it already passed.
          if (!ram_vld || !wt_rd_vld_i) begin
            res_found_d = 1'b0;
            state_d     = ST_FIN;
          end else if (cnt_q == CW'(NUM_LOCKS - 1)) begin
            res_found_d = 1'b1;
            state_d     = ST_FIN;
          end else begin
            cnt_d       = cnt_q + 1'b1;
            ram_raddr_o = wt_rd_lock_i;
          end
        end else begin
          if (!ram_vld) begin
            res_tail_d = cur_wide[3:0];
            state_d    = ST_FIN;
          end else if (cnt_q == CW'(NUM_LOCKS)) begin
            res_tail_d = cur_wide[3:0];
            res_cyc_d  = 1'b1;
            state_d    = ST_FIN;
          end else begin
            cur_d = ram_thread;
            cnt_d = cnt_q + 1'b1;
            if (!wt_rd_vld_i) begin
              res_tail_d = nxt_wide[3:0];
              state_d    = ST_FIN;
            end else begin
              ram_raddr_o = wt_rd_lock_i;
            end
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      tail_mode_q <= 1'b0;
      cnt_q       <= '0;
      cur_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tail_mode_q <= tail_mode_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= res_found_d;
    res_tail_q  <= res_tail_d;
    res_cyc_q   <= res_cyc_d;
    if (out_load) begin
      deadlock_found_o <= res_found_q;
      tail_thread_o    <= res_tail_q;
      chain_cycled_o   <= res_cyc_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= CW'(NUM_LOCKS)))
    else $error("walk step count beyond the lock count");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(deadlock_found_o && chain_cycled_o))
    else $error("deadlock and cycle flags set in one result");

  a_ram_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> ((state_q == ST_CLR) || accept))
    else $error("owner table written outside clear pass or update");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised without finishing an item");
`endif

endmodule
